// ===== hw/rtl/geared_output_angle_tracker_macros.svh =====
// Assertion macros used by the geared output angle tracker RTL.
`ifndef GEARED_OUTPUT_ANGLE_TRACKER_MACROS_SVH
`define GEARED_OUTPUT_ANGLE_TRACKER_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define GOAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define GOAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/goat_pkg.sv =====
// Package: widths and angle constants for the geared output angle tracker.
`timescale 1ns / 1ps
package goat_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ANGLE_W   = 26;
  localparam int OUT_W     = 25;
  localparam int TURN_W    = 32;
  localparam int RATIO_W   = 16;

  // 360 degrees needs 9 integer bits above the fraction
  localparam int FULLT_W = FRAC_BITS + 9;
  localparam int TOTAL_W = TURN_W + FULLT_W + 1;
  localparam int MAG_W   = TOTAL_W;
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int CMP_W   = ((ANGLE_W + 1) > (FULLT_W + 1)) ? (ANGLE_W + 1) : (FULLT_W + 1);

  localparam longint FULL_TURN_I = longint'(360) << FRAC_BITS;
  localparam longint HALF_TURN_I = longint'(180) << FRAC_BITS;

  localparam logic [FULLT_W-1:0] FULL_TURN = FULLT_W'(FULL_TURN_I);
  localparam logic [FULLT_W-1:0] HALF_TURN = FULLT_W'(HALF_TURN_I);

  localparam logic signed [TURN_W-1:0] TURN_LIM = {1'b0, {(TURN_W-1){1'b1}}};

endpackage

// ===== hw/rtl/goat_divmod.sv =====
// Bit-serial unit: |total| / ratio, quotient bits folded on the fly modulo 360 deg.
`timescale 1ns / 1ps
module goat_divmod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [goat_pkg::MAG_W-1:0]    dividend,
  input  logic [goat_pkg::RATIO_W-1:0]  divisor,
  output logic                          done,
  output logic [goat_pkg::FULLT_W-1:0]  modulo
);
  import goat_pkg::*;

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [MAG_W-1:0]     shreg;
  logic [RATIO_W-1:0]   rem;

  logic [RATIO_W:0]     shifted;
  logic                 qbit;
  logic [RATIO_W-1:0]   rem_next;
  logic [FULLT_W:0]     macc_dbl;
  logic [FULLT_W-1:0]   macc_next;

  // one restoring step; the quotient bit feeds the mod-360 accumulator
  always_comb begin
    shifted  = {rem, shreg[MAG_W-1]};
    qbit     = (shifted >= {1'b0, divisor});
    rem_next = qbit ? RATIO_W'(shifted - {1'b0, divisor}) : RATIO_W'(shifted);
    macc_dbl = {modulo, qbit};
    if (macc_dbl >= {1'b0, FULL_TURN}) begin
      macc_next = FULLT_W'(macc_dbl - {1'b0, FULL_TURN});
    end else begin
      macc_next = FULLT_W'(macc_dbl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && !start && (cnt == '0);
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg  <= dividend;
      rem    <= '0;
      modulo <= '0;
      cnt    <= CNT_W'(MAG_W - 1);
    end else if (running) begin
      shreg  <= {shreg[MAG_W-2:0], 1'b0};
      rem    <= rem_next;
      modulo <= macc_next;
      cnt    <= cnt - CNT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/geared_output_angle_tracker.sv =====
// Geared output angle tracker: unwraps motor turns, divides by the ratio, folds the result.
// Sequence per sample: turn update, multiply, magnitude, bit-serial divide, fold, output load.
// A new sample is taken only once the previous result is loaded; the divider sets the pace.
// in_stall is high from acceptance until the result is loaded into the output register.
// Reset (rst, synchronous): gear ratio 1, turn count 0, first sample pending, no result.
// Config writes are taken every cycle (cfg_ready tied high); write only while idle.
`timescale 1ns / 1ps
module geared_output_angle_tracker (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [goat_pkg::ANGLE_W-1:0] motor_angle,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [goat_pkg::OUT_W-1:0]   shaft_angle,
  output logic signed [goat_pkg::TURN_W-1:0]  turn_count,
  output logic                                turns_saturated,
  // gear ratio register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [goat_pkg::RATIO_W-1:0]        cfg_data
);
  import goat_pkg::*;

`include "geared_output_angle_tracker_macros.svh"

  // sequencer
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample
  localparam logic [2:0] S_TURN = 3'd1;  // wrap detection, turn count update
  localparam logic [2:0] S_MUL  = 3'd2;  // turns * 360 deg
  localparam logic [2:0] S_ABS  = 3'd3;  // add sample, take magnitude, kick divider
  localparam logic [2:0] S_DIV  = 3'd4;  // divider running
  localparam logic [2:0] S_FOLD = 3'd5;  // fold to (-180,180], load output

  logic [2:0]                 state;
  logic [RATIO_W-1:0]         reduction;
  logic signed [ANGLE_W-1:0]  cur;
  logic signed [ANGLE_W-1:0]  prev_angle;
  logic signed [TURN_W-1:0]   turns;
  logic                       first_pending;
  logic signed [TOTAL_W-1:0]  prod;
  logic                       neg;

  logic                       in_accept;
  logic signed [CMP_W-1:0]    delta;
  logic signed [CMP_W-1:0]    half_cmp;
  logic signed [TOTAL_W-1:0]  prod_next;
  logic signed [TOTAL_W-1:0]  total;
  logic [MAG_W-1:0]           mag;
  logic [RATIO_W-1:0]         divisor;
  logic                       div_start;
  logic                       div_done;
  logic [FULLT_W-1:0]         modulo;
  logic signed [FULLT_W:0]    folded;
  logic                       out_free;
  logic                       out_load;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_FOLD) && out_free;

  // zero ratio behaves as one
  assign divisor   = (reduction == '0) ? RATIO_W'(1) : reduction;
  assign div_start = (state == S_ABS);

  always_comb begin
    delta     = CMP_W'(cur) - CMP_W'(prev_angle);
    half_cmp  = $signed(CMP_W'({1'b0, HALF_TURN}));
    prod_next = TOTAL_W'(turns) * $signed(TOTAL_W'(FULL_TURN));
    total     = prod + TOTAL_W'(cur);
    mag       = total[TOTAL_W-1] ? MAG_W'(-total) : MAG_W'(total);
    // truncating remainder keeps the dividend's sign, then fold the half-open range
    if (!neg) begin
      if (modulo > HALF_TURN) begin
        folded = $signed({1'b0, modulo}) - $signed({1'b0, FULL_TURN});
      end else begin
        folded = $signed({1'b0, modulo});
      end
    end else begin
      if (modulo >= HALF_TURN) begin
        folded = $signed({1'b0, FULL_TURN}) - $signed({1'b0, modulo});
      end else begin
        folded = -$signed({1'b0, modulo});
      end
    end
  end

  goat_divmod u_divmod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (divisor),
    .done     (div_done),
    .modulo   (modulo)
  );

  // gear ratio register
  always_ff @(posedge clk) begin
    if (rst) begin
      reduction <= RATIO_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      reduction <= cfg_data;
    end
  end

  // control and tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_angle    <= '0;
      turns         <= '0;
      first_pending <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_TURN;
          end
        end
        S_TURN: begin
          // first sample only records; later ones count wraps, saturating
          if (first_pending) begin
            first_pending <= 1'b0;
          end else if (delta > half_cmp) begin
            if (turns > -TURN_LIM) begin
              turns <= turns - TURN_W'(1);
            end
          end else if (delta < -half_cmp) begin
            if (turns < TURN_LIM) begin
              turns <= turns + TURN_W'(1);
            end
          end
          prev_angle <= cur;
          state      <= S_MUL;
        end
        S_MUL: begin
          state <= S_ABS;
        end
        S_ABS: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          // hold here while an older result is still waiting
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur <= motor_angle;
    end
    if (state == S_MUL) begin
      prod <= prod_next;
    end
    if (state == S_ABS) begin
      neg <= total[TOTAL_W-1];
    end
    if (out_load) begin
      shaft_angle     <= OUT_W'(folded);
      turn_count      <= turns;
      turns_saturated <= (turns == TURN_LIM) || (turns == -TURN_LIM);
    end
  end

  // checks
  `GOAT_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall,
                    "sample channel not stalled after a transaction")
  `GOAT_ASSERT_NOW(a_done_in_div, div_done, state == S_DIV,
                   "divider finished outside the divide phase")
  `GOAT_ASSERT_NEXT(a_turns_only_in_turn, state != S_TURN, $stable(turns),
                    "turn count moved outside the update phase")
  `GOAT_ASSERT_NOW(a_sat_flag, out_valid,
                   turns_saturated == ((turn_count == TURN_LIM) || (turn_count == -TURN_LIM)),
                   "saturation flag disagrees with turn count")
  `GOAT_ASSERT_NOW(a_angle_range, out_valid,
                   (shaft_angle <= $signed(OUT_W'(HALF_TURN))) &&
                   (shaft_angle > -$signed(OUT_W'(HALF_TURN))),
                   "shaft angle out of the half-open range")

endmodule

// ===== tb/geared_output_angle_tracker_checker.sv =====
// Checker: predicts the tracker's results from observed transactions and compares them.
`timescale 1ns / 1ps
module geared_output_angle_tracker_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [goat_pkg::ANGLE_W-1:0] motor_angle,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [goat_pkg::OUT_W-1:0]   shaft_angle,
  input  logic signed [goat_pkg::TURN_W-1:0]  turn_count,
  input  logic                                turns_saturated,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [goat_pkg::RATIO_W-1:0]        cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output longint                              turns_low,
  output longint                              turns_high
);
  import goat_pkg::*;

  localparam longint TURN_MAX = 64'sd2147483647;

  typedef struct packed {
    logic signed [OUT_W-1:0]  angle;
    logic signed [TURN_W-1:0] turns;
    logic                     saturated;
  } shaft_result_t;

  shaft_result_t      shaft_expect_q[$];
  logic [RATIO_W-1:0] ratio_reg;
  longint             prev_sample;
  longint             turn_acc;
  bit                 awaiting_first;
  int                 result_idx;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t checker: %s", $time, msg);
  endfunction

  // Unwrap one sample, then divide by the ratio and fold into (-180,180].
  function automatic shaft_result_t predict_shaft(input logic signed [ANGLE_W-1:0] sample);
    longint        cur;
    longint        delta;
    longint        divisor;
    longint        folded;
    shaft_result_t res;
    cur = longint'(sample);
    if (awaiting_first) begin
      awaiting_first = 1'b0;
    end else begin
      delta = cur - prev_sample;
      if (delta > HALF_TURN_I) begin
        if (turn_acc > -TURN_MAX) turn_acc--;
      end else if (delta < -HALF_TURN_I) begin
        if (turn_acc < TURN_MAX) turn_acc++;
      end
    end
    prev_sample = cur;
    divisor = (ratio_reg == '0) ? 64'sd1 : longint'(ratio_reg);
    folded = ((cur + turn_acc * FULL_TURN_I) / divisor) % FULL_TURN_I;
    if (folded > HALF_TURN_I) folded -= FULL_TURN_I;
    if (folded <= -HALF_TURN_I) folded += FULL_TURN_I;
    res.angle     = folded[OUT_W-1:0];
    res.turns     = turn_acc[TURN_W-1:0];
    res.saturated = (turn_acc == TURN_MAX) || (turn_acc == -TURN_MAX);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    shaft_result_t want;
    if (rst) begin
      ratio_reg      = 16'd1;
      prev_sample    = 0;
      turn_acc       = 0;
      awaiting_first = 1'b1;
      result_idx     = 0;
      fail_count     = 0;
      turns_low      = 0;
      turns_high     = 0;
      shaft_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) ratio_reg = cfg_data;
      // compare before pushing, so a result can never match a sample of the same edge
      if (out_valid && !out_stall) begin
        if (shaft_expect_q.size() == 0) begin
          note_failure($sformatf("unexpected result: angle %0d, turns %0d, saturated %0b",
                                 shaft_angle, turn_count, turns_saturated));
        end else begin
          want = shaft_expect_q.pop_front();
          if (shaft_angle !== want.angle)
            note_failure($sformatf("result %0d shaft_angle: expected %0d, got %0d",
                                   result_idx, want.angle, shaft_angle));
          if (turn_count !== want.turns)
            note_failure($sformatf("result %0d turn_count: expected %0d, got %0d",
                                   result_idx, want.turns, turn_count));
          if (turns_saturated !== want.saturated)
            note_failure($sformatf("result %0d turns_saturated: expected %0b, got %0b",
                                   result_idx, want.saturated, turns_saturated));
          result_idx++;
        end
      end
      if (in_valid && !in_stall) begin
        shaft_expect_q.push_back(predict_shaft(motor_angle));
        if (turn_acc < turns_low) turns_low = turn_acc;
        if (turn_acc > turns_high) turns_high = turn_acc;
      end
    end
    pending = shaft_expect_q.size();
  end

endmodule

// ===== tb/geared_output_angle_tracker_tb.sv =====
// Testbench top: angle samples, gear ratio writes, back-pressure and the verdict.
`timescale 1ns / 1ps
module geared_output_angle_tracker_tb;
  import goat_pkg::*;

  localparam int     SAMPLE_TARGET = 1900;  // rough size of the whole run
  localparam int     OPENING_LEN   = 22;
  localparam int     RANDOM_PHASES = 16;
  localparam int     HOLD_CYCLES   = 400;   // long output hold-off, well beyond one item time
  localparam int     DEAD_LIMIT    = 4000;  // cycles without any transaction before giving up
  localparam int     TAIL_CYCLES   = 100;   // idle margin after the last result
  localparam longint DEG           = longint'(1) << FRAC_BITS;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] motor_angle = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic signed [OUT_W-1:0]   shaft_angle;
  logic signed [TURN_W-1:0]  turn_count;
  logic                      turns_saturated;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [RATIO_W-1:0]        cfg_data    = '0;

  // checker outputs
  int     fail_count;
  int     pending;
  longint turns_low;
  longint turns_high;

  // bookkeeping on the stimulus side
  int   samples_sent = 0;
  int   results_seen = 0;
  int   ratio_writes = 0;
  int   dead_cycles  = 0;
  bit   gaps_on      = 1'b1;
  logic quiet        = 1'b0;  // end of run: neither side idles

  // receiver state: burst counters and the long hold-off request
  int hold_gen   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_left = 0;
  int free_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  geared_output_angle_tracker dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .motor_angle     (motor_angle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .shaft_angle     (shaft_angle),
    .turn_count      (turn_count),
    .turns_saturated (turns_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  geared_output_angle_tracker_checker shaft_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .motor_angle     (motor_angle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .shaft_angle     (shaft_angle),
    .turn_count      (turn_count),
    .turns_saturated (turns_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .turns_low       (turns_low),
    .turns_high      (turns_high)
  );

  // Result side. A hold-off request wins over everything else and keeps out_stall
  // high for the whole hold-off; meanwhile the sender keeps offering, so the block's
  // output register fills and in_stall stays up. Otherwise random stall bursts and
  // free stretches follow one another, and no new burst starts once quiet is set.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
      free_left  <= 0;
    end else if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (free_left != 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else if (!quiet && $urandom_range(0, 2) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      free_left <= $urandom_range(0, 30);
      out_stall <= 1'b0;
    end
  end

  // Every sample gives exactly one result, so equal counts mean the block is idle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles == DEAD_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", DEAD_LIMIT);
      $display("geared_output_angle_tracker_tb: done, errors");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  // Offer one sample and hold it until the block takes it. in_valid stays high
  // afterwards; the caller lowers it only for a gap or at a phase boundary.
  task automatic send_sample(input longint value);
    in_valid    <= 1'b1;
    motor_angle <= value[ANGLE_W-1:0];
    do @(posedge clk); while (in_stall !== 1'b0);
    samples_sent++;
  endtask

  task automatic sender_pause();
    if (gaps_on && !quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drain: drop valid and wait for the last result to be taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != samples_sent) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_ratio(input logic [RATIO_W-1:0] ratio);
    cfg_valid <= 1'b1;
    cfg_data  <= ratio;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ratio_writes++;
  endtask

  initial begin : stimulus
    // Opening walk. Ratio 1 from reset for the first 12, then 0, 65535 and 7.
    // Covers: first sample only recording (360 deg), jumps of exactly +/-180
    // (no turn), one LSB past +/-180 (turn down / up), the range ends, and the
    // raw 26-bit extremes outside the stated range.
    longint opening[OPENING_LEN] = '{
      23592960, -11796480, 0, 11796480, 0, 11796481, 0, -1, 1,
      -33554432, 33554431, -11796479,
      5898240, -5898240, 23592959,
      33554431, -33554432, 12345, -11796480,
      23592960, 11796480, -11796480
    };
    longint             shaft_pos;
    longint             base_step;
    longint             step;
    longint             sample;
    logic [RATIO_W-1:0] ratio_pick;
    int                 phase_end;
    int                 per_phase;
    int                 seg_len;
    int                 kind;
    bit                 spin_fwd;
    bit                 signed_wrap;

    shaft_pos   = 0;
    spin_fwd    = 1'b1;
    signed_wrap = 1'b1;
    per_phase   = (SAMPLE_TARGET - OPENING_LEN) / RANDOM_PHASES;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < OPENING_LEN; i++) begin
      if (i == 12 || i == 15 || i == 19) begin
        wait_idle();
        write_ratio(i == 12 ? 16'd0 : (i == 15 ? 16'hFFFF : 16'd7));
      end
      send_sample(opening[i]);
      sender_pause();
    end

    // Random phases: each one starts idle with a new ratio. Most samples come
    // from a motor turning in one direction for a while, wrapped in either the
    // signed or the unsigned convention, so the turn count wanders far from
    // zero. The rest are uniform in-range samples and raw 26-bit patterns.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:                 ratio_pick = 16'd0;
        1:                 ratio_pick = 16'hFFFF;
        2:                 ratio_pick = 16'd1;
        RANDOM_PHASES - 1: ratio_pick = 16'hFFFF;
        default: begin
          case ($urandom_range(0, 3))
            0:       ratio_pick = RATIO_W'($urandom_range(2, 10));
            1:       ratio_pick = RATIO_W'($urandom_range(11, 1000));
            2:       ratio_pick = RATIO_W'($urandom_range(0, 1));
            default: ratio_pick = RATIO_W'($urandom);
          endcase
        end
      endcase
      write_ratio(ratio_pick);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (ph == 5 || ph == 11) hold_gen <= hold_gen + 1;
      if (ph == RANDOM_PHASES - 2) quiet <= 1'b1;
      phase_end = samples_sent + per_phase;

      while (samples_sent < phase_end) begin
        kind    = $urandom_range(0, 9);
        seg_len = $urandom_range(8, 60);
        if (seg_len > phase_end - samples_sent) seg_len = phase_end - samples_sent;
        if ($urandom_range(0, 4) == 0) spin_fwd = !spin_fwd;
        if ($urandom_range(0, 5) == 0) signed_wrap = !signed_wrap;
        base_step = longint'($urandom_range(0, 179 * 65536));
        for (int n = 0; n < seg_len; n++) begin
          if (kind < 7) begin
            // speed jitters by up to one degree, kept below half a turn
            step = base_step + longint'($urandom_range(0, 2 * 65536)) - DEG;
            if (step < 0) step = 0;
            if (step > 179 * DEG) step = 179 * DEG;
            shaft_pos += spin_fwd ? step : -step;
            if (signed_wrap) begin
              while (shaft_pos > HALF_TURN_I) shaft_pos -= FULL_TURN_I;
              while (shaft_pos <= -HALF_TURN_I) shaft_pos += FULL_TURN_I;
            end else begin
              while (shaft_pos >= FULL_TURN_I) shaft_pos -= FULL_TURN_I;
              while (shaft_pos < 0) shaft_pos += FULL_TURN_I;
            end
            sample = shaft_pos;
          end else if (kind < 9) begin
            sample = longint'($urandom_range(0, 35389440)) - 11796480;
          end else begin
            sample = longint'($urandom);
          end
          send_sample(sample);
          sender_pause();
        end
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d samples over %0d gear ratio writes (0, 1 and 65535 included)",
             samples_sent, ratio_writes);
    $display("turn count swept %0d..%0d; output held off %0d cycles twice under load",
             turns_low, turns_high, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("geared_output_angle_tracker_tb: done, clean");
    end else begin
      if (pending != 0) $display("%0d expected results never arrived", pending);
      $display("geared_output_angle_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== geared_output_angle_tracker.f =====
+incdir+hw/rtl
hw/rtl/goat_pkg.sv
hw/rtl/goat_divmod.sv
hw/rtl/geared_output_angle_tracker.sv
tb/geared_output_angle_tracker_checker.sv
tb/geared_output_angle_tracker_tb.sv
